// ----- src/vmt_pkg.sv -----
// Shared types, command codes and register indexes for the vertex matrix transform.
// No dependencies; every other file imports this package.
`default_nettype none
package vmt_pkg;

   localparam int WORD_W         = 32;
   localparam int CMD_W          = 3;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int DOT_STAGES     = 5;
   localparam int DIV_RADIX_BITS = 4;

   localparam logic [CMD_W-1:0] CMD_AFFINE     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PROJECT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ROTATE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INV_ROTATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INV_XFORM  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_VEC4       = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_R0_C01 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_R0_C23 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_R1_C01 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_R1_C23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_R2_C01 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_R2_C23 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_R3_C01 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_R3_C23 = 3'd7;

   localparam logic [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef logic [3:0][WORD_W-1:0]      vec4_type;
   typedef logic [3:0][3:0][WORD_W-1:0] mat_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      vec4_type         res;
      logic [3:0]       sat;
   } side_type;

   // quotient steps of the divider: 2*|v| << frac over a 32-bit divisor
   function automatic int div_iters(input int frac_bits);
      return (frac_bits + WORD_W + 1 + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   endfunction

endpackage
`default_nettype wire

// ----- src/vmt_dot_pipe.sv -----
// Four-column dot-product pipeline: operand select, multiply, add tree, round and clamp.
// Depends on vmt_pkg.
`default_nettype none
module vmt_dot_pipe
   import vmt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic [DOT_STAGES-1:0]    adv,
   input  logic [CMD_W-1:0]         cmd,
   input  logic signed [WORD_W-1:0] in_x,
   input  logic signed [WORD_W-1:0] in_y,
   input  logic signed [WORD_W-1:0] in_z,
   input  logic signed [WORD_W-1:0] in_w,
   input  mat_type                  mat,
   output side_type                 result
);

   localparam int OPA_W  = WORD_W + 1;
   localparam int PROD_W = OPA_W + WORD_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SH_W   = SUM_W - FRAC_BITS;
   localparam logic signed [OPA_W-1:0] ONE_Q  = OPA_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] HALF_Q = SUM_W'(1) << (FRAC_BITS - 1);

   logic signed [WORD_W-1:0] vin [4];
   logic [WORD_W-1:0]        tr  [4];
   logic signed [OPA_W-1:0]  a_in [4];
   logic signed [OPA_W-1:0]  a_ff [4];
   logic signed [WORD_W-1:0] b_in [4][4];
   logic signed [WORD_W-1:0] b_ff [4][4];
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [SUM_W-1:0]  s01_ff [4];
   logic signed [SUM_W-1:0]  s23_ff [4];
   logic signed [SUM_W-1:0]  tot_ff [4];
   logic [CMD_W-1:0]         cmd_ff [4];
   logic [SH_W-1:0]          sh [4];
   side_type                 result_in;
   side_type                 result_ff;

   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;
   assign vin[3] = in_w;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_in[k] = '0;
         tr[k]   = (cmd == CMD_INV_XFORM) ? mat[3][k] : '0;
         for (int c = 0; c < 4; c++) begin
            b_in[c][k] = '0;
         end
      end
      case (cmd) inside
         CMD_AFFINE, CMD_PROJECT, CMD_ROTATE, CMD_VEC4: begin
            for (int k = 0; k < 3; k++) begin
               a_in[k] = OPA_W'(vin[k]);
            end
            if (cmd == CMD_VEC4) begin
               a_in[3] = OPA_W'(vin[3]);
            end else if (cmd == CMD_ROTATE) begin
               a_in[3] = '0;
            end else begin
               a_in[3] = ONE_Q;
            end
            for (int c = 0; c < 4; c++) begin
               for (int k = 0; k < 4; k++) begin
                  b_in[c][k] = mat[k][c];
               end
            end
            // drop the w column unless it is part of the result
            if (cmd != CMD_PROJECT && cmd != CMD_VEC4) begin
               for (int k = 0; k < 4; k++) begin
                  b_in[3][k] = '0;
               end
            end
         end
         CMD_INV_ROTATE, CMD_INV_XFORM: begin
            for (int k = 0; k < 3; k++) begin
               a_in[k] = OPA_W'(vin[k]) - OPA_W'($signed(tr[k]));
            end
            for (int c = 0; c < 3; c++) begin
               for (int k = 0; k < 3; k++) begin
                  b_in[c][k] = mat[c][k];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         cmd_ff[0] <= cmd;
      end
      if (adv[1]) begin
         for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
               prod_ff[c][k] <= a_ff[k] * b_ff[c][k];
            end
         end
         cmd_ff[1] <= cmd_ff[0];
      end
      if (adv[2]) begin
         for (int c = 0; c < 4; c++) begin
            s01_ff[c] <= SUM_W'(prod_ff[c][0]) + SUM_W'(prod_ff[c][1]) + HALF_Q;
            s23_ff[c] <= SUM_W'(prod_ff[c][2]) + SUM_W'(prod_ff[c][3]);
         end
         cmd_ff[2] <= cmd_ff[1];
      end
      if (adv[3]) begin
         for (int c = 0; c < 4; c++) begin
            tot_ff[c] <= s01_ff[c] + s23_ff[c];
         end
         cmd_ff[3] <= cmd_ff[2];
      end
      if (adv[4]) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      result_in.cmd = cmd_ff[3];
      for (int c = 0; c < 4; c++) begin
         sh[c] = tot_ff[c][SUM_W-1:FRAC_BITS];
         if ((&sh[c][SH_W-1:WORD_W-1]) || !(|sh[c][SH_W-1:WORD_W-1])) begin
            result_in.res[c] = sh[c][WORD_W-1:0];
            result_in.sat[c] = 1'b0;
         end else begin
            result_in.res[c] = sh[c][SH_W-1] ? Q_MIN : Q_MAX;
            result_in.sat[c] = 1'b1;
         end
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

// ----- src/vmt_div_pipe.sv -----
// Pipelined radix-16 restoring divider: (num << FRAC_BITS) / den, rounded, clamped.
// Depends on vmt_pkg.
`default_nettype none
module vmt_div_pipe
   import vmt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic [div_iters(FRAC_BITS)+1:0]     adv,
   input  logic [WORD_W-1:0]                   num,
   input  logic [WORD_W-1:0]                   den,
   output logic [WORD_W-1:0]                   quot,
   output logic                                sat
);

   localparam int ITERS = div_iters(FRAC_BITS);
   localparam int QB    = ITERS * DIV_RADIX_BITS;

   logic [QB-1:0]     dvd_ff [ITERS+1];
   logic [WORD_W-1:0] rem_ff [ITERS+1];
   logic [WORD_W-1:0] d_ff   [ITERS+1];
   logic              neg_ff [ITERS+1];
   logic [WORD_W-1:0] n_abs;
   logic [WORD_W-1:0] d_abs;
   logic [QB:0]       q_inc;
   logic [QB-1:0]     q;
   logic              big;
   logic [WORD_W-1:0] quot_in;
   logic              sat_in;
   logic [WORD_W-1:0] quot_ff;
   logic              sat_ff;

   assign n_abs = num[WORD_W-1] ? (~num + 1'b1) : num;
   assign d_abs = den[WORD_W-1] ? (~den + 1'b1) : den;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dvd_ff[0] <= QB'(n_abs) << (FRAC_BITS + 1);
         rem_ff[0] <= '0;
         d_ff[0]   <= d_abs;
         neg_ff[0] <= num[WORD_W-1] ^ den[WORD_W-1];
      end
   end

   for (genvar j = 0; j < ITERS; j++) begin : g_iter
      logic [QB-1:0]     dvd_nx;
      logic [WORD_W-1:0] rem_nx;

      always_comb begin
         logic [WORD_W:0] trial;
         dvd_nx = dvd_ff[j];
         rem_nx = rem_ff[j];
         for (int b = 0; b < DIV_RADIX_BITS; b++) begin
            trial  = {rem_nx, dvd_nx[QB-1]};
            dvd_nx = {dvd_nx[QB-2:0], 1'b0};
            if (trial >= {1'b0, d_ff[j]}) begin
               trial     = trial - {1'b0, d_ff[j]};
               dvd_nx[0] = 1'b1;
            end
            rem_nx = trial[WORD_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j+1]) begin
            dvd_ff[j+1] <= dvd_nx;
            rem_ff[j+1] <= rem_nx;
            d_ff[j+1]   <= d_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
      end
   end

   // quotient carries one extra fraction bit: add it back for round-half-away
   always_comb begin
      q_inc = {1'b0, dvd_ff[ITERS]} + (QB+1)'(1);
      q     = q_inc[QB:1];
      big   = |q[QB-1:WORD_W];
      if (neg_ff[ITERS]) begin
         sat_in  = big || (q[WORD_W-1] && (|q[WORD_W-2:0]));
         quot_in = sat_in ? Q_MIN : (~q[WORD_W-1:0] + 1'b1);
      end else begin
         sat_in  = big || q[WORD_W-1];
         quot_in = sat_in ? Q_MAX : q[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ITERS+1]) begin
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule
`default_nettype wire

// ----- src/vertex_matrix_transform.sv -----
// Path: every command passes through the dot-product stages, the radix-16 divider stages
// and the output register; the radix-16 divider pipeline sets most of that depth.
// Throughput: one beat per cycle while rsp_stall is low; each stage holds one item and moves when the next frees.
// Reset clears all valid bits and loads the identity matrix.
// Depends on vmt_pkg, vmt_dot_pipe and vmt_div_pipe.
`default_nettype none
module vertex_matrix_transform
   import vmt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [WORD_W-1:0] req_in_x,
   input  logic signed [WORD_W-1:0] req_in_y,
   input  logic signed [WORD_W-1:0] req_in_z,
   input  logic signed [WORD_W-1:0] req_in_w,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_out_x,
   output logic signed [WORD_W-1:0] rsp_out_y,
   output logic signed [WORD_W-1:0] rsp_out_z,
   output logic signed [WORD_W-1:0] rsp_out_w,
   output logic                     rsp_saturated,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DIV_STAGES = div_iters(FRAC_BITS) + 2;
   localparam int NUM_STAGES = DOT_STAGES + DIV_STAGES + 1;
   localparam int LAST       = NUM_STAGES - 1;
   localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

   mat_type                 mat_ff;
   mat_type                 mat_in;
   logic [WORD_W-1:0]       wr_lo;
   logic [WORD_W-1:0]       wr_hi;
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES-1:0]   ready;
   side_type                dot_out;
   side_type                side_ff [DIV_STAGES];
   side_type                side_in [DIV_STAGES];
   side_type                side_last;
   logic [2:0][WORD_W-1:0]  quot;
   logic [2:0]              div_sat;
   vec4_type                out_in;
   vec4_type                out_ff;
   logic                    osat_in;
   logic                    osat_ff;

   // matrix registers
   assign wr_lo = csr_wdata[WORD_W-1:0];
   assign wr_hi = csr_wdata[CSR_DATA_W-1:WORD_W];

   always_comb begin
      mat_in = mat_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_R0_C01: begin mat_in[0][0] = wr_lo; mat_in[0][1] = wr_hi; end
            REG_R0_C23: begin mat_in[0][2] = wr_lo; mat_in[0][3] = wr_hi; end
            REG_R1_C01: begin mat_in[1][0] = wr_lo; mat_in[1][1] = wr_hi; end
            REG_R1_C23: begin mat_in[1][2] = wr_lo; mat_in[1][3] = wr_hi; end
            REG_R2_C01: begin mat_in[2][0] = wr_lo; mat_in[2][1] = wr_hi; end
            REG_R2_C23: begin mat_in[2][2] = wr_lo; mat_in[2][3] = wr_hi; end
            REG_R3_C01: begin mat_in[3][0] = wr_lo; mat_in[3][1] = wr_hi; end
            REG_R3_C23: begin mat_in[3][2] = wr_lo; mat_in[3][3] = wr_hi; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               mat_ff[r][c] <= (r == c) ? ONE_Q : '0;
            end
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   // stage valid bits; a stage advances when empty or when the next one advances
   always_comb begin
      ready[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign valid_in = {valid_ff[LAST-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[LAST];

   vmt_dot_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dot (
      .clock  (clock),
      .adv    (ready[DOT_STAGES-1:0]),
      .cmd    (req_command),
      .in_x   (req_in_x),
      .in_y   (req_in_y),
      .in_z   (req_in_z),
      .in_w   (req_in_w),
      .mat    (mat_ff),
      .result (dot_out)
   );

   for (genvar c = 0; c < 3; c++) begin : g_div
      vmt_div_pipe #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock (clock),
         .adv   (ready[DOT_STAGES +: DIV_STAGES]),
         .num   (dot_out.res[c]),
         .den   (dot_out.res[3]),
         .quot  (quot[c]),
         .sat   (div_sat[c])
      );
   end

   // carry the dot results alongside the dividers
   always_comb begin
      side_in[0] = dot_out;
      for (int i = 1; i < DIV_STAGES; i++) begin
         side_in[i] = side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (ready[DOT_STAGES+i]) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign side_last = side_ff[DIV_STAGES-1];

   always_comb begin
      out_in  = side_last.res;
      osat_in = |side_last.sat;
      if (side_last.cmd == CMD_PROJECT) begin
         if (side_last.res[3] == '0) begin
            out_in  = '0;
            osat_in = 1'b0;
         end else begin
            for (int c = 0; c < 3; c++) begin
               out_in[c] = quot[c];
            end
            osat_in = (|side_last.sat) || (|div_sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[LAST]) begin
         out_ff  <= out_in;
         osat_ff <= osat_in;
      end
   end

   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_out_w     = out_ff[3];
   assign rsp_saturated = osat_ff;

`ifndef SYNTH
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled with a free stage");

   a_accept_fills_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat missing from first stage");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (mat_ff[3][3] == ONE_Q && mat_ff[0][0] == ONE_Q && !rsp_valid))
      else $error("reset did not load identity or clear valids");
`endif

endmodule
`default_nettype wire
